### hdl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// A condition that implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/lrwo_pkg.sv
package lrwo_pkg;

	// Width of the coordinate fields on the ports.
	localparam int FIELD_BITS = 14;

	// Default width of the coordinates that the rasteriser works with.
	localparam int COORD_BITS_DEF = 14;

	// Most pixels that one beat can produce, and the depth of the result queue.
	localparam int MAX_RESULTS = 3;
	localparam int QUEUE_DEPTH = 4;

	// Codes of the mode field.
	localparam logic MODE_START   = 1'b0;
	localparam logic MODE_ADVANCE = 1'b1;

	// Bits of the overlap field.
	localparam int OVL_MAJOR = 0;
	localparam int OVL_MINOR = 1;

endpackage

### hdl/line_rasterizer_with_overlap.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    mode, x_start, y_start, x_end, y_end, overlap
// output    out        out_valid / out_stall  pixel_x, pixel_y, last
//
// An input beat is registered, then worked on once at most one pixel is queued;
// the line state is updated and its zero to three pixels enter a four-entry queue.
// One input beat a cycle is taken while no more than one pixel waits in the queue.
// Pixels leave the queue one a cycle while out_stall is low, and the input stalls
// while a beat waits in the input register and two or more pixels are queued.
// A beat's pixels pass through the input register, then the result queue.
// Reset clears the line state and the queue at once; there is no clearing pass.
module line_rasterizer_with_overlap #(
	parameter int COORD_BITS = lrwo_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic signed [lrwo_pkg::FIELD_BITS-1:0] x_start,
	input  logic signed [lrwo_pkg::FIELD_BITS-1:0] y_start,
	input  logic signed [lrwo_pkg::FIELD_BITS-1:0] x_end,
	input  logic signed [lrwo_pkg::FIELD_BITS-1:0] y_end,
	input  logic [1:0]                            overlap,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [lrwo_pkg::FIELD_BITS-1:0] pixel_x,
	output logic signed [lrwo_pkg::FIELD_BITS-1:0] pixel_y,
	output logic                                  last
);

	import lrwo_pkg::*;

	`include "assert_macros.svh"

	localparam int CW      = COORD_BITS;
	localparam int ERRW    = COORD_BITS + 3;
	localparam int PTRW    = $clog2(QUEUE_DEPTH);
	localparam int CNTW    = $clog2(QUEUE_DEPTH + 1);
	localparam int NPW     = $clog2(MAX_RESULTS + 1);
	localparam int ROOM_AT = QUEUE_DEPTH - MAX_RESULTS;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 last;
	} pix_t;

	// Input register.
	logic                 valid_s1;
	logic                 mode_s1;
	logic signed [CW-1:0] xs_s1, ys_s1, xe_s1, ye_s1;
	logic [1:0]           ovl_s1;

	// Line state.
	logic                 busy_q;
	logic signed [CW-1:0] cur_x_q, cur_y_q, end_major_q;
	logic signed [ERRW-1:0] err_q;
	logic [CW:0]          tmaj_q, tmin_q;
	logic                 sxn_q, syn_q, xmaj_q;
	logic [1:0]           ovl_q;

	// Result queue.
	pix_t            queue_q [QUEUE_DEPTH];
	logic [PTRW-1:0] rd_ptr_q, wr_ptr_q;
	logic [CNTW-1:0] cnt_q;

	logic in_acc, process, pop;

	assign in_stall  = valid_s1 && (cnt_q > CNTW'(ROOM_AT));
	assign in_acc    = in_valid && !in_stall;
	assign process   = valid_s1 && (cnt_q <= CNTW'(ROOM_AT));
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;

	// Register the input beat; coordinates keep their low COORD_BITS bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1 <= mode;
			xs_s1   <= x_start[CW-1:0];
			ys_s1   <= y_start[CW-1:0];
			xe_s1   <= x_end[CW-1:0];
			ye_s1   <= y_end[CW-1:0];
			ovl_s1  <= overlap;
		end
	end

	// Set-up of a new line: deltas, direction and the initial error.
	logic signed [CW:0]   dx, dy;
	logic [CW:0]          adx, ady;
	logic                 st_xmaj, st_busy;
	logic [CW:0]          st_tmaj, st_tmin;
	logic signed [ERRW-1:0] st_err;
	logic signed [CW-1:0] st_end;

	always_comb begin
		dx      = {xe_s1[CW-1], xe_s1} - {xs_s1[CW-1], xs_s1};
		dy      = {ye_s1[CW-1], ye_s1} - {ys_s1[CW-1], ys_s1};
		adx     = dx[CW] ? (CW+1)'(-dx) : dx;
		ady     = dy[CW] ? (CW+1)'(-dy) : dy;
		st_xmaj = adx > ady;
		if (st_xmaj) begin
			st_tmaj = {adx[CW-1:0], 1'b0};
			st_tmin = {ady[CW-1:0], 1'b0};
			st_err  = {2'b00, ady[CW-1:0], 1'b0} - {3'b000, adx[CW-1:0]};
			st_end  = xe_s1;
			st_busy = (xs_s1 != xe_s1);
		end else begin
			st_tmaj = {ady[CW-1:0], 1'b0};
			st_tmin = {adx[CW-1:0], 1'b0};
			st_err  = {2'b00, adx[CW-1:0], 1'b0} - {3'b000, ady[CW-1:0]};
			st_end  = ye_s1;
			st_busy = (ys_s1 != ye_s1);
		end
	end

	// One step along the major axis with the overlap pixels that it brings, or the first pixel of a new line.
	logic signed [CW-1:0] nx, ny, adv_x, adv_y, major_now;
	logic                 minor_step, adv_busy;
	logic signed [ERRW-1:0] adv_err;
	pix_t                 new_pix [MAX_RESULTS];
	logic [NPW-1:0]       n_push;

	always_comb begin
		nx         = sxn_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
		ny         = syn_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
		minor_step = !err_q[ERRW-1];
		adv_x      = (xmaj_q || minor_step) ? nx : cur_x_q;
		adv_y      = (!xmaj_q || minor_step) ? ny : cur_y_q;
		major_now  = xmaj_q ? adv_x : adv_y;
		adv_busy   = (major_now != end_major_q);
		adv_err    = err_q + {2'b00, tmin_q}
			- (minor_step ? {2'b00, tmaj_q} : ERRW'(0));

		for (int k = 0; k < MAX_RESULTS; k++) begin
			new_pix[k] = '0;
		end
		n_push = '0;
		if (mode_s1 == MODE_START) begin
			new_pix[0] = '{x: xs_s1, y: ys_s1, last: !st_busy};
			n_push     = NPW'(1);
		end else if (busy_q) begin
			if (minor_step && ovl_q[OVL_MAJOR]) begin
				if (xmaj_q) begin
					new_pix[n_push] = '{x: nx, y: cur_y_q, last: 1'b0};
				end else begin
					new_pix[n_push] = '{x: cur_x_q, y: ny, last: 1'b0};
				end
				n_push = n_push + NPW'(1);
			end
			if (minor_step && ovl_q[OVL_MINOR]) begin
				if (xmaj_q) begin
					new_pix[n_push] = '{x: cur_x_q, y: ny, last: 1'b0};
				end else begin
					new_pix[n_push] = '{x: nx, y: cur_y_q, last: 1'b0};
				end
				n_push = n_push + NPW'(1);
			end
			new_pix[n_push] = '{x: adv_x, y: adv_y, last: !adv_busy};
			n_push = n_push + NPW'(1);
		end
		if (!process) begin
			n_push = '0;
		end
	end

	// Line state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			end_major_q <= '0;
			err_q       <= '0;
			tmaj_q      <= '0;
			tmin_q      <= '0;
			sxn_q       <= 1'b0;
			syn_q       <= 1'b0;
			xmaj_q      <= 1'b0;
			ovl_q       <= '0;
		end else if (process) begin
			if (mode_s1 == MODE_START) begin
				busy_q      <= st_busy;
				cur_x_q     <= xs_s1;
				cur_y_q     <= ys_s1;
				end_major_q <= st_end;
				err_q       <= st_err;
				tmaj_q      <= st_tmaj;
				tmin_q      <= st_tmin;
				sxn_q       <= dx[CW];
				syn_q       <= dy[CW];
				xmaj_q      <= st_xmaj;
				ovl_q       <= ovl_s1;
			end else if (busy_q) begin
				busy_q  <= adv_busy;
				cur_x_q <= adv_x;
				cur_y_q <= adv_y;
				err_q   <= adv_err;
			end
		end
	end

	// Result queue: up to three pixels written per cycle, one read per cycle while out_stall is low.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTRW'(1);
			end
			wr_ptr_q <= wr_ptr_q + PTRW'(n_push);
			cnt_q    <= cnt_q + CNTW'(n_push) - CNTW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (NPW'(k) < n_push) begin
				queue_q[wr_ptr_q + PTRW'(k)] <= new_pix[k];
			end
		end
	end

	// Output beat from the head of the queue, widened to the port fields.
	pix_t head;
	assign head    = queue_q[rd_ptr_q];
	assign pixel_x = FIELD_BITS'(head.x);
	assign pixel_y = FIELD_BITS'(head.y);
	assign last    = head.last;

	// Checks on the queue and the stage handshake.
	`ASSERT_ALWAYS(a_queue_bound, clk, arst_n, cnt_q <= CNTW'(QUEUE_DEPTH), "queue overfilled")
	`ASSERT_IMPLIES(a_stage_moves, clk, arst_n, in_acc && valid_s1, process, "input register overwritten")
	`ASSERT_NEXT(a_no_push_idle, clk, arst_n, !valid_s1, cnt_q <= $past(cnt_q), "push without a beat")

endmodule

### tb/sv/line_rasterizer_with_overlap_test.sv
module line_rasterizer_with_overlap_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lrwo_pkg::*;

	localparam int W = FIELD_BITS;
	localparam int COORD_MIN = -(1 << (W - 1));
	localparam int COORD_MAX = (1 << (W - 1)) - 1;
	localparam int SETTLE_CYCLES = 10;
	localparam int STALL_LIMIT = 2000;
	localparam int BEATS_PER_PHASE = 100;

	localparam logic [1:0] OVL_NONE = 2'b00;
	localparam logic [1:0] OVL_JUST_MAJOR = 2'(1 << OVL_MAJOR);
	localparam logic [1:0] OVL_JUST_MINOR = 2'(1 << OVL_MINOR);
	localparam logic [1:0] OVL_BOTH = OVL_JUST_MAJOR | OVL_JUST_MINOR;

	typedef logic signed [W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} pixel_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	logic   mode;
	coord_t x_start;
	coord_t y_start;
	coord_t x_end;
	coord_t y_end;
	logic [1:0] overlap;
	logic   out_valid;
	logic   out_stall = 1'b0;
	coord_t pixel_x;
	coord_t pixel_y;
	logic   last;

	line_rasterizer_with_overlap uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.overlap(overlap),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.last(last)
	);

	// Pixels still owed by the block, oldest first.
	pixel_t expected_pixels[$];
	pixel_t oldest_pixel;
	int     mismatches = 0;
	int     quiet_cycles = 0;
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;

	// Our own copy of the line state.
	logic               line_active = 1'b0;
	coord_t             pen_x = '0;
	coord_t             pen_y = '0;
	coord_t             major_goal = '0;
	logic signed [16:0] err_acc = '0;
	logic [14:0]        major_span2 = '0;
	logic [14:0]        minor_span2 = '0;
	logic               x_backward = 1'b0;
	logic               y_backward = 1'b0;
	logic               along_x = 1'b0;
	logic [1:0]         ovl_mode = '0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic owe_pixel(input int px, input int py, input logic is_end);
		pixel_t p;
		p.x = coord_t'(px);
		p.y = coord_t'(py);
		p.last = is_end;
		expected_pixels = {expected_pixels, p};
	endtask

	// Bresenham step: works out the pixels that one accepted beat produces.
	task automatic rasterize_beat(input logic m, input coord_t xs, input coord_t ys,
			input coord_t xe, input coord_t ye, input logic [1:0] ovl);
		int dx, dy, sx, sy, e, px, py, major_pos;
		if (m == MODE_START) begin
			dx = int'(xe) - int'(xs);
			dy = int'(ye) - int'(ys);
			x_backward = dx < 0;
			y_backward = dy < 0;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			ovl_mode = ovl;
			pen_x = xs;
			pen_y = ys;
			// Ties in length go to the Y axis.
			along_x = dx > dy;
			if (along_x) begin
				major_span2 = 15'(2 * dx);
				minor_span2 = 15'(2 * dy);
				err_acc = 17'(2 * dy - dx);
				major_goal = xe;
				line_active = xs != xe;
			end else begin
				major_span2 = 15'(2 * dy);
				minor_span2 = 15'(2 * dx);
				err_acc = 17'(2 * dx - dy);
				major_goal = ye;
				line_active = ys != ye;
			end
			owe_pixel(int'(xs), int'(ys), !line_active);
		end else if (line_active) begin
			sx = x_backward ? -1 : 1;
			sy = y_backward ? -1 : 1;
			px = int'(pen_x);
			py = int'(pen_y);
			e = int'(err_acc);
			if (along_x) begin
				px += sx;
				if (e >= 0) begin
					if (ovl_mode[OVL_MAJOR]) owe_pixel(px, py, 1'b0);
					py += sy;
					if (ovl_mode[OVL_MINOR]) owe_pixel(px - sx, py, 1'b0);
					e -= int'(major_span2);
				end
				major_pos = px;
			end else begin
				py += sy;
				if (e >= 0) begin
					if (ovl_mode[OVL_MAJOR]) owe_pixel(px, py, 1'b0);
					px += sx;
					if (ovl_mode[OVL_MINOR]) owe_pixel(px, py - sy, 1'b0);
					e -= int'(major_span2);
				end
				major_pos = py;
			end
			e += int'(minor_span2);
			err_acc = 17'(e);
			pen_x = coord_t'(px);
			pen_y = coord_t'(py);
			if (major_pos == int'(major_goal)) line_active = 1'b0;
			owe_pixel(px, py, !line_active);
		end
	endtask

	// Offers one input beat, with random idle cycles first, and waits until it is taken.
	task automatic send_beat(input logic m, input coord_t xs, input coord_t ys,
			input coord_t xe, input coord_t ye, input logic [1:0] ovl);
		logic taken;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		x_start <= xs;
		y_start <= ys;
		x_end <= xe;
		y_end <= ye;
		overlap <= ovl;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !in_stall;
		end
		rasterize_beat(m, xs, ys, xe, ye, ovl);
	endtask

	// Advance beats carry random junk in the coordinate fields, which the block ignores.
	task automatic step_line(input int count);
		repeat (count)
			send_beat(MODE_ADVANCE, coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), coord_t'($urandom), 2'($urandom));
	endtask

	// Holds the input quiet until every owed pixel has come out.
	task automatic drain_pixels();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic coord_t near_coord(input coord_t base, input int reach);
		int c;
		c = int'(base) + $urandom_range(2 * reach) - reach;
		if (c > COORD_MAX || c < COORD_MIN)
			c = 2 * int'(base) - c;
		return coord_t'(c);
	endfunction

	task automatic test_idle_advance();
		step_line(1);
		drain_pixels();
	endtask

	// A line whose start equals its end is a single pixel flagged as last.
	task automatic test_single_point();
		send_beat(MODE_START, coord_t'(COORD_MAX), coord_t'(COORD_MIN),
			coord_t'(COORD_MAX), coord_t'(COORD_MIN), OVL_BOTH);
		step_line(1);
		drain_pixels();
	endtask

	// Corner to corner lines, each abandoned by the next start.
	task automatic test_extreme_restart();
		send_beat(MODE_START, coord_t'(COORD_MIN), coord_t'(COORD_MIN),
			coord_t'(COORD_MAX), coord_t'(COORD_MAX), OVL_BOTH);
		step_line(2);
		send_beat(MODE_START, coord_t'(COORD_MAX), coord_t'(COORD_MIN),
			coord_t'(COORD_MIN), coord_t'(COORD_MAX), OVL_BOTH);
		step_line(2);
		drain_pixels();
	endtask

	// Short complete lines with major-only, minor-only and no overlap, on both major axes.
	task automatic test_overlap_lines();
		send_beat(MODE_START, coord_t'(0), coord_t'(0), coord_t'(4), coord_t'(2),
			OVL_JUST_MAJOR);
		step_line(5);
		send_beat(MODE_START, coord_t'(3), coord_t'(4), coord_t'(1), coord_t'(0),
			OVL_JUST_MINOR);
		step_line(4);
		send_beat(MODE_START, coord_t'(-3), coord_t'(1), coord_t'(-6), coord_t'(2),
			OVL_NONE);
		step_line(3);
		drain_pixels();
	endtask

	// Mostly whole short lines; some are cut short, overrun or span the full range.
	task automatic test_random_lines(input int quota);
		int done, pick, adv, span, ax, ay;
		coord_t xs, ys, xe, ye;
		done = 0;
		while (done < quota) begin
			pick = $urandom_range(99);
			xs = coord_t'($urandom);
			ys = coord_t'($urandom);
			if (pick < 8) begin
				xe = coord_t'($urandom);
				ye = coord_t'($urandom);
				adv = $urandom_range(4);
			end else begin
				xe = near_coord(xs, (pick < 15) ? 40 : 8);
				ye = near_coord(ys, (pick < 15) ? 40 : 8);
				ax = int'(xe) - int'(xs);
				ay = int'(ye) - int'(ys);
				if (ax < 0) ax = -ax;
				if (ay < 0) ay = -ay;
				span = (ax > ay) ? ax : ay;
				pick = $urandom_range(99);
				if (pick < 70)
					adv = span;
				else if (pick < 85)
					adv = $urandom_range(span);
				else
					adv = span + $urandom_range(1, 2);
			end
			send_beat(MODE_START, xs, ys, xe, ye, 2'($urandom));
			done++;
			repeat (adv) begin
				if (line_active) done++;
				step_line(1);
			end
			if ($urandom_range(29) == 0) drain_pixels();
		end
		drain_pixels();
	endtask

	// Output side stalls at random, decided at each falling edge.
	always @(negedge clk)
		out_stall <= $urandom_range(99) < recv_idle_pct;

	// Compare every pixel beat with the oldest owed pixel.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				$display("%0t unexpected pixel x=%0d y=%0d last=%0b", $time,
					pixel_x, pixel_y, last);
			end else begin
				oldest_pixel = expected_pixels.pop_front();
				if (pixel_x !== oldest_pixel.x || pixel_y !== oldest_pixel.y
						|| last !== oldest_pixel.last) begin
					mismatches++;
					$display("%0t mismatch: expected %0d,%0d,%0b got %0d,%0d,%0b",
						$time, oldest_pixel.x, oldest_pixel.y, oldest_pixel.last,
						pixel_x, pixel_y, last);
				end
			end
		end
	end

	// Ends the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t no beat moved for %0d cycles", $time, STALL_LIMIT);
				$display("[line_rasterizer_with_overlap] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_START;
		x_start = '0;
		y_start = '0;
		x_end = '0;
		y_end = '0;
		overlap = OVL_NONE;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 22;
		recv_idle_pct = 85;
		test_idle_advance();
		test_single_point();
		test_extreme_restart();
		test_overlap_lines();
		test_random_lines(BEATS_PER_PHASE);

		send_idle_pct = 85;
		recv_idle_pct = 22;
		test_random_lines(BEATS_PER_PHASE);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_lines(BEATS_PER_PHASE);

		drain_pixels();
		if (mismatches == 0)
			$display("[line_rasterizer_with_overlap] OK");
		else
			$display("[line_rasterizer_with_overlap] ERROR");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/lrwo_pkg.sv
hdl/line_rasterizer_with_overlap.sv
tb/sv/line_rasterizer_with_overlap_test.sv
